// ===== sv/twrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-wire RTC serial port package
// Shared codes, types and helper functions for the serial port blocks.
// ----------------------------------------------------------------------------
package twrtc_pkg;

   // Port buffer geometry.
   localparam int BUFFER_BYTES = 8;
   localparam int BUF_IDX_W    = 3;
   localparam int CLOCK_BYTES  = 7;
   localparam int TIME_BYTES   = 3;
   // Hour is the first of the three time-only bytes in the date/time buffer.
   localparam int TIME_FIRST   = 4;

   // Protocol phases.
   localparam logic [1:0] PHASE_COMMAND   = 2'd0;
   localparam logic [1:0] PHASE_RECEIVING = 2'd1;
   localparam logic [1:0] PHASE_SENDING   = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_STATUS_ONE = 3'd0;
   localparam logic [2:0] REG_STATUS_TWO = 3'd1;
   localparam logic [2:0] REG_DATE_TIME  = 3'd2;
   localparam logic [2:0] REG_TIME       = 3'd3;
   localparam logic [2:0] REG_ALARM_ONE  = 3'd4;
   localparam logic [2:0] REG_ALARM_TWO  = 3'd5;
   localparam logic [2:0] REG_ADJUST     = 3'd6;
   localparam logic [2:0] REG_FREE       = 3'd7;

   // Nibble that marks a valid command byte.
   localparam logic [3:0] CMD_MARKER = 4'b0110;
   // Bits of status one that a write may change.
   localparam logic [7:0] STATUS_ONE_MASK = 8'h0E;

   // One port access as seen by the engine.
   typedef struct packed {
      logic       opcode;
      logic [7:0] port_value;
   } step_type;

   // One result beat.
   typedef struct packed {
      logic [6:0] port_readback;
      logic       command_error;
   } result_type;

   // Current date and time in BCD: year, month, day, weekday, hour, minute, second.
   typedef logic [CLOCK_BYTES-1:0][7:0] clock_bytes_type;

   // Number of bytes that each register transfers.
   function automatic logic [2:0] reg_byte_count(input logic [2:0] sel);
      logic [2:0] count;
      unique case (sel)
         REG_STATUS_ONE: count = 3'd1;
         REG_STATUS_TWO: count = 3'd1;
         REG_DATE_TIME:  count = 3'd7;
         REG_TIME:       count = 3'd3;
         REG_ALARM_ONE:  count = 3'd3;
         REG_ALARM_TWO:  count = 3'd3;
         REG_ADJUST:     count = 3'd1;
         REG_FREE:       count = 3'd1;
         default:        count = 3'd1;
      endcase
      return count;
   endfunction

   // Reverse the bit order of a byte.
   function automatic logic [7:0] bit_reverse(input logic [7:0] d);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = d[7-i];
      end
      return r;
   endfunction

   // Binary to BCD for values below 128. Tens come from a multiply by the
   // reciprocal of ten (205/2048), which is exact over this range.
   function automatic logic [7:0] bcd_byte(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  rest;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      rest = v - 7'(7'(tens) * 7'd10);
      return {tens, rest[3:0]};
   endfunction

endpackage

// ===== sv/three_wire_rtc_serial_port_top.sv =====
// ----------------------------------------------------------------------------
// Three-wire RTC serial port
// Top level: input register, protocol engine and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one port access per beat: req_opcode 0 reads the
//   port back, 1 writes req_port_value (SIO/SCK/CS in bits 0-2, their write
//   enables in bits 4-6). The req_now_* fields give the current date and
//   time, sampled when a read command is recognized.
//   The rsp_ channel returns one beat per access: the port levels and enables
//   after the access, and command_error when the access completed a command
//   byte of unknown format.
//   An accepted req_ beat passes the input register and the result register
//   before rsp_valid. One beat is taken every cycle unless a stalled result
//   blocks it; the engine step between the two registers is combinational.
//   When rsp_stall is high with a result waiting, the input register holds
//   one more beat and then req_stall rises; nothing is dropped.
//   Reset clears the lines, the enables, the status registers and puts the
//   engine back into command phase; the port is usable the cycle after.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_port_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_port_value,
   input  logic [6:0] req_now_year,
   input  logic [3:0] req_now_month,
   input  logic [4:0] req_now_day,
   input  logic [2:0] req_now_weekday,
   input  logic [4:0] req_now_hour,
   input  logic [5:0] req_now_minute,
   input  logic [5:0] req_now_second,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_port_readback,
   output logic       rsp_command_error
);
   import twrtc_pkg::*;

   logic            in_valid_ff;
   logic            in_opcode_ff;
   logic [7:0]      in_port_value_ff;
   logic [6:0]      in_year_ff;
   logic [3:0]      in_month_ff;
   logic [4:0]      in_day_ff;
   logic [2:0]      in_weekday_ff;
   logic [4:0]      in_hour_ff;
   logic [5:0]      in_minute_ff;
   logic [5:0]      in_second_ff;
   logic            rsp_valid_ff;
   result_type      rsp_ff;
   logic            advance;
   step_type        step;
   clock_bytes_type clock_bytes;
   result_type      result;

   // The input beat moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_opcode_ff     <= req_opcode;
         in_port_value_ff <= req_port_value;
         in_year_ff       <= req_now_year;
         in_month_ff      <= req_now_month;
         in_day_ff        <= req_now_day;
         in_weekday_ff    <= req_now_weekday;
         in_hour_ff       <= req_now_hour;
         in_minute_ff     <= req_now_minute;
         in_second_ff     <= req_now_second;
      end
   end

   assign step.opcode     = in_opcode_ff;
   assign step.port_value = in_port_value_ff;

   twrtc_clock_fmt u_clock_fmt (
      .now_year    (in_year_ff),
      .now_month   (in_month_ff),
      .now_day     (in_day_ff),
      .now_weekday (in_weekday_ff),
      .now_hour    (in_hour_ff),
      .now_minute  (in_minute_ff),
      .now_second  (in_second_ff),
      .clock_bytes (clock_bytes)
   );

   twrtc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step        (step),
      .clock_bytes (clock_bytes),
      .result      (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_port_readback = rsp_ff.port_readback;
   assign rsp_command_error = rsp_ff.command_error;

   // Every beat that leaves the input register shows up as a result.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("input beat advanced without a result");

   // A stalled result beat stays valid and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result beat changed");

   // The input side stalls only behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without a stalled result");

endmodule

// ===== sv/twrtc_clock_fmt.sv =====
// ----------------------------------------------------------------------------
// Three-wire RTC clock formatter
// Converts the current binary date and time fields into BCD buffer bytes.
// ----------------------------------------------------------------------------
module twrtc_clock_fmt (
   input  logic [6:0]                 now_year,
   input  logic [3:0]                 now_month,
   input  logic [4:0]                 now_day,
   input  logic [2:0]                 now_weekday,
   input  logic [4:0]                 now_hour,
   input  logic [5:0]                 now_minute,
   input  logic [5:0]                 now_second,
   output twrtc_pkg::clock_bytes_type clock_bytes
);
   import twrtc_pkg::*;

   // Byte order follows the date/time register layout.
   assign clock_bytes[0] = bcd_byte(now_year);
   assign clock_bytes[1] = bcd_byte(7'(now_month));
   assign clock_bytes[2] = bcd_byte(7'(now_day));
   assign clock_bytes[3] = bcd_byte(7'(now_weekday));
   assign clock_bytes[4] = bcd_byte(7'(now_hour));
   assign clock_bytes[5] = bcd_byte(7'(now_minute));
   assign clock_bytes[6] = bcd_byte(7'(now_second));

endmodule

// ===== sv/twrtc_engine.sv =====
// ----------------------------------------------------------------------------
// Three-wire RTC protocol engine
// Holds the line levels and the serial protocol state, and works out one
// port access per cycle.
// ----------------------------------------------------------------------------
module twrtc_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_valid,
   input  twrtc_pkg::step_type        step,
   input  twrtc_pkg::clock_bytes_type clock_bytes,
   output twrtc_pkg::result_type      result
);
   import twrtc_pkg::*;

   logic [2:0]           lines_ff, lines_in;
   logic [2:0]           enables_ff, enables_in;
   logic [2:0]           bit_pos_ff, bit_pos_in;
   logic [BUF_IDX_W-1:0] byte_pos_ff, byte_pos_in;
   logic [7:0]           shift_ff, shift_in;
   logic [1:0]           phase_ff, phase_in;
   logic [2:0]           sel_ff, sel_in;
   logic [7:0]           status_one_ff, status_one_in;
   logic [7:0]           status_two_ff, status_two_in;
   logic [7:0]           buf_ff [BUFFER_BYTES];
   logic [7:0]           buf_in [BUFFER_BYTES];

   logic [2:0]           we;
   logic [7:0]           shifted;
   logic [7:0]           cmd;
   logic [2:0]           count;
   logic [7:0]           cur;
   logic                 err;

   // Next state for one port access.
   always_comb begin
      lines_in      = lines_ff;
      enables_in    = enables_ff;
      bit_pos_in    = bit_pos_ff;
      byte_pos_in   = byte_pos_ff;
      shift_in      = shift_ff;
      phase_in      = phase_ff;
      sel_in        = sel_ff;
      status_one_in = status_one_ff;
      status_two_in = status_two_ff;
      buf_in        = buf_ff;
      we            = step.port_value[6:4];
      shifted       = shift_ff;
      cmd           = shift_ff;
      count         = reg_byte_count(sel_ff);
      cur           = buf_ff[byte_pos_ff];
      err           = 1'b0;

      if (step_valid && step.opcode) begin
         enables_in = we;
         lines_in   = (lines_ff & ~we) | (step.port_value[2:0] & we);

         // A rising chip select restarts command reception.
         if (!lines_ff[2] && lines_in[2]) begin
            phase_in    = PHASE_COMMAND;
            bit_pos_in  = 3'd0;
            byte_pos_in = '0;
         end

         shifted             = shift_ff;
         shifted[bit_pos_in] = lines_in[0];
         cur                 = buf_ff[byte_pos_in];

         // Falling serial clock with chip select high moves one bit.
         if (lines_in[2] && lines_ff[1] && !lines_in[1]) begin
            unique case (phase_in)
               PHASE_COMMAND: begin
                  shift_in   = shifted;
                  bit_pos_in = bit_pos_in + 3'd1;
                  if (bit_pos_in == 3'd0) begin
                     if (shifted[7:4] == CMD_MARKER) begin
                        cmd = bit_reverse(shifted);
                     end else begin
                        cmd = shifted;
                     end
                     shift_in = cmd;
                     if (shifted[7:4] != CMD_MARKER && shifted[3:0] != CMD_MARKER) begin
                        err = 1'b1;
                     end else begin
                        sel_in      = cmd[6:4];
                        byte_pos_in = '0;
                        if (cmd[7]) begin
                           // Read command: fill the buffer with the register bytes.
                           for (int i = 0; i < BUFFER_BYTES; i++) begin
                              if (i < CLOCK_BYTES) begin
                                 buf_in[i] = 8'h00;
                              end
                           end
                           unique case (cmd[6:4])
                              REG_STATUS_ONE: buf_in[0] = status_one_ff;
                              REG_STATUS_TWO: buf_in[0] = status_two_ff;
                              REG_DATE_TIME: begin
                                 for (int i = 0; i < CLOCK_BYTES; i++) begin
                                    buf_in[i] = clock_bytes[i];
                                 end
                              end
                              REG_TIME: begin
                                 for (int i = 0; i < TIME_BYTES; i++) begin
                                    buf_in[i] = clock_bytes[TIME_FIRST+i];
                                 end
                              end
                              default: ;
                           endcase
                           phase_in = PHASE_SENDING;
                        end else begin
                           phase_in = PHASE_RECEIVING;
                        end
                     end
                  end
               end
               PHASE_RECEIVING: begin
                  if (byte_pos_in < count) begin
                     shift_in   = shifted;
                     bit_pos_in = bit_pos_in + 3'd1;
                     if (bit_pos_in == 3'd0) begin
                        byte_pos_in = byte_pos_in + BUF_IDX_W'(1);
                        // Status registers take one byte, so the last byte is byte zero.
                        if (byte_pos_in == count) begin
                           if (sel_ff == REG_STATUS_ONE) begin
                              status_one_in = (status_one_ff & ~STATUS_ONE_MASK)
                                            | (shifted & STATUS_ONE_MASK);
                           end else if (sel_ff == REG_STATUS_TWO) begin
                              status_two_in = shifted;
                           end
                           phase_in = PHASE_COMMAND;
                        end
                     end
                  end
               end
               PHASE_SENDING: begin
                  lines_in[0]         = cur[0];
                  buf_in[byte_pos_in] = {1'b0, cur[7:1]};
                  bit_pos_in          = bit_pos_in + 3'd1;
                  if (bit_pos_in == 3'd0) begin
                     byte_pos_in = byte_pos_in + BUF_IDX_W'(1);
                     if (byte_pos_in == count) begin
                        phase_in = PHASE_COMMAND;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign result.port_readback = {enables_in, 1'b0, lines_in};
   assign result.command_error = err;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff      <= '0;
         enables_ff    <= '0;
         bit_pos_ff    <= '0;
         byte_pos_ff   <= '0;
         shift_ff      <= '0;
         phase_ff      <= PHASE_COMMAND;
         sel_ff        <= '0;
         status_one_ff <= '0;
         status_two_ff <= '0;
      end else begin
         lines_ff      <= lines_in;
         enables_ff    <= enables_in;
         bit_pos_ff    <= bit_pos_in;
         byte_pos_ff   <= byte_pos_in;
         shift_ff      <= shift_in;
         phase_ff      <= phase_in;
         sel_ff        <= sel_in;
         status_one_ff <= status_one_in;
         status_two_ff <= status_two_in;
      end
   end

   // Transfer buffer; every byte sent is loaded first, so it needs no reset.
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // A port read leaves the line and protocol state alone.
   assert property (@(posedge clock) disable iff (reset)
      (step_valid && !step.opcode) |=> ($stable(lines_ff) && $stable(phase_ff)
                                         && $stable(shift_ff)))
      else $error("port read changed engine state");

   // A rejected command byte leaves the engine waiting for a new command.
   assert property (@(posedge clock) disable iff (reset)
      result.command_error |=> (phase_ff == PHASE_COMMAND && bit_pos_ff == 3'd0))
      else $error("engine left command phase after a bad command");

   // While sending, the byte position stays inside the register's length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_SENDING) |-> (byte_pos_ff < reg_byte_count(sel_ff)))
      else $error("send position past register length");

endmodule

// ===== tb/tb_three_wire_rtc_serial_port_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the three-wire RTC serial port
// Drives port reads and writes that bit-bang the SIO/SCK/CS lines: command
// bytes in both bit orders, malformed commands, status, clock and unused
// register transfers, cut-off transfers and raw noise. Every result beat is
// checked against an in-bench prediction of the port under changing idle and
// stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_three_wire_rtc_serial_port_top;
   import twrtc_pkg::*;

   // Port access codes.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Bits of a written port byte.
   localparam logic [7:0] LINE_SIO = 8'h01;
   localparam logic [7:0] LINE_SCK = 8'h02;
   localparam logic [7:0] LINE_CS  = 8'h04;
   localparam logic [7:0] WE_SIO   = 8'h10;
   localparam logic [7:0] WE_SCK   = 8'h20;
   localparam logic [7:0] WE_CS    = 8'h40;
   localparam logic [7:0] IGNORED_BITS = 8'h88;

   // Current date and time as presented on the req_now_ ports.
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } rtc_now_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_opcode;
   logic [7:0] req_port_value;
   logic [6:0] req_now_year;
   logic [3:0] req_now_month;
   logic [4:0] req_now_day;
   logic [2:0] req_now_weekday;
   logic [4:0] req_now_hour;
   logic [5:0] req_now_minute;
   logic [5:0] req_now_second;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [6:0] rsp_port_readback;
   logic       rsp_command_error;

   three_wire_rtc_serial_port_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_port_value    (req_port_value),
      .req_now_year      (req_now_year),
      .req_now_month     (req_now_month),
      .req_now_day       (req_now_day),
      .req_now_weekday   (req_now_weekday),
      .req_now_hour      (req_now_hour),
      .req_now_minute    (req_now_minute),
      .req_now_second    (req_now_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_port_readback (rsp_port_readback),
      .rsp_command_error (rsp_command_error)
   );

   // Predicted port state.
   logic [2:0] line_lv;
   logic [2:0] line_we;
   logic [2:0] bit_idx;
   logic [2:0] byte_idx;
   logic [7:0] shifter;
   logic [1:0] xfer_phase;
   logic [2:0] cur_reg;
   logic [7:0] xfer_buf [BUFFER_BYTES];
   logic [7:0] stat_one;
   logic [7:0] stat_two;

   // Results still owed by the port, oldest first.
   result_type port_result_q[$];

   rtc_now_type cur_now;
   logic        now_fixed = 1'b0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          beats_sent = 0;
   int          mismatches = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run if it hangs.
   initial begin
      #1_000_000;
      $display("tb_three_wire_rtc_serial_port_top: done, errors");
      $finish;
   end

   // Number of bytes each register moves after its command byte.
   function automatic int xfer_length(input logic [2:0] sel);
      case (sel)
         REG_DATE_TIME: return 7;
         REG_TIME, REG_ALARM_ONE, REG_ALARM_TWO: return 3;
         default: return 1;
      endcase
   endfunction

   // Mirror a byte end for end by swapping nibbles, pairs and single bits.
   function automatic logic [7:0] flip_byte(input logic [7:0] d);
      logic [7:0] r;
      r = {d[3:0], d[7:4]};
      r = ((r & 8'h33) << 2) | ((r & 8'hCC) >> 2);
      r = ((r & 8'h55) << 1) | ((r & 8'hAA) >> 1);
      return r;
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   // Latch SIO into the shifter, LSB first. Returns 1 when a byte is complete.
   function automatic logic shift_in_bit();
      shifter[bit_idx] = line_lv[0];
      bit_idx = bit_idx + 3'd1;
      return bit_idx == 3'd0;
   endfunction

   // Advance the predicted port by one access and return the result beat.
   function automatic result_type rtc_port_step(input logic op, input logic [7:0] val,
                                                input rtc_now_type now);
      result_type r;
      logic       old_sck;
      logic       old_cs;
      logic       err;
      logic [7:0] d;
      logic [7:0] b;
      int         n;
      err = 1'b0;
      if (op == OP_WRITE) begin
         old_sck = line_lv[1];
         old_cs  = line_lv[2];
         line_we = val[6:4];
         line_lv = (line_lv & ~val[6:4]) | (val[2:0] & val[6:4]);
         // Rising chip select restarts command reception.
         if (!old_cs && line_lv[2]) begin
            xfer_phase = PHASE_COMMAND;
            bit_idx = 3'd0;
            byte_idx = 3'd0;
         end
         // Falling SCK with chip select high moves one bit.
         if (line_lv[2] && old_sck && !line_lv[1]) begin
            n = xfer_length(cur_reg);
            case (xfer_phase)
               PHASE_COMMAND: begin
                  if (shift_in_bit()) begin
                     d = shifter;
                     if (d[7:4] == CMD_MARKER) begin
                        d = flip_byte(d);
                        shifter = d;
                     end
                     if (d[3:0] != CMD_MARKER) begin
                        err = 1'b1;
                     end else begin
                        cur_reg = d[6:4];
                        bit_idx = 3'd0;
                        byte_idx = 3'd0;
                        if (d[7]) begin
                           // Read: fill the buffer, then shift it out.
                           for (int i = 0; i < 7; i++) xfer_buf[i] = 8'h00;
                           case (cur_reg)
                              REG_STATUS_ONE: xfer_buf[0] = stat_one;
                              REG_STATUS_TWO: xfer_buf[0] = stat_two;
                              REG_DATE_TIME: begin
                                 xfer_buf[0] = to_bcd(32'(now.year));
                                 xfer_buf[1] = to_bcd(32'(now.month));
                                 xfer_buf[2] = to_bcd(32'(now.day));
                                 xfer_buf[3] = to_bcd(32'(now.weekday));
                                 xfer_buf[4] = to_bcd(32'(now.hour));
                                 xfer_buf[5] = to_bcd(32'(now.minute));
                                 xfer_buf[6] = to_bcd(32'(now.second));
                              end
                              REG_TIME: begin
                                 xfer_buf[0] = to_bcd(32'(now.hour));
                                 xfer_buf[1] = to_bcd(32'(now.minute));
                                 xfer_buf[2] = to_bcd(32'(now.second));
                              end
                              default: ;
                           endcase
                           xfer_phase = PHASE_SENDING;
                        end else begin
                           xfer_phase = PHASE_RECEIVING;
                        end
                     end
                  end
               end
               PHASE_RECEIVING: begin
                  if (int'(byte_idx) < n) begin
                     if (shift_in_bit()) begin
                        xfer_buf[byte_idx] = shifter;
                        byte_idx = byte_idx + 3'd1;
                        if (int'(byte_idx) == n) begin
                           // Only the status registers keep what was written.
                           if (cur_reg == REG_STATUS_ONE) begin
                              stat_one = (stat_one & ~STATUS_ONE_MASK)
                                         | (xfer_buf[0] & STATUS_ONE_MASK);
                           end else if (cur_reg == REG_STATUS_TWO) begin
                              stat_two = xfer_buf[0];
                           end
                           xfer_phase = PHASE_COMMAND;
                        end
                     end
                  end
               end
               PHASE_SENDING: begin
                  b = xfer_buf[byte_idx];
                  line_lv[0] = b[0];
                  xfer_buf[byte_idx] = b >> 1;
                  bit_idx = bit_idx + 3'd1;
                  if (bit_idx == 3'd0) begin
                     byte_idx = byte_idx + 3'd1;
                     if (int'(byte_idx) == n) xfer_phase = PHASE_COMMAND;
                  end
               end
               default: ;
            endcase
         end
      end
      r.port_readback = {line_we, 1'b0, line_lv};
      r.command_error = err;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   // Result side: the receiver stalls at random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = !reset && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (port_result_q.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, readback 0x%0h",
                                      rsp_port_readback));
         end else begin
            want = port_result_q.pop_front();
            if (rsp_port_readback !== want.port_readback)
               report_mismatch($sformatf("port_readback expected 0x%0h got 0x%0h",
                                         want.port_readback, rsp_port_readback));
            if (rsp_command_error !== want.command_error)
               report_mismatch($sformatf("command_error expected %0b got %0b",
                                         want.command_error, rsp_command_error));
         end
      end
   end

   // Send one port access; waits out random sender gaps and the stall.
   task automatic send_beat(input logic op, input logic [7:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      // Mostly calendar-legal time, sometimes anything the fields can hold.
      if (!now_fixed) begin
         if ($urandom_range(4) == 0) begin
            cur_now.year    = 7'($urandom);
            cur_now.month   = 4'($urandom);
            cur_now.day     = 5'($urandom);
            cur_now.weekday = 3'($urandom);
            cur_now.hour    = 5'($urandom);
            cur_now.minute  = 6'($urandom);
            cur_now.second  = 6'($urandom);
         end else begin
            cur_now.year    = 7'($urandom_range(99));
            cur_now.month   = 4'($urandom_range(12, 1));
            cur_now.day     = 5'($urandom_range(31, 1));
            cur_now.weekday = 3'($urandom_range(6));
            cur_now.hour    = 5'($urandom_range(23));
            cur_now.minute  = 6'($urandom_range(59));
            cur_now.second  = 6'($urandom_range(59));
         end
      end
      req_opcode      = op;
      req_port_value  = val;
      req_now_year    = cur_now.year;
      req_now_month   = cur_now.month;
      req_now_day     = cur_now.day;
      req_now_weekday = cur_now.weekday;
      req_now_hour    = cur_now.hour;
      req_now_minute  = cur_now.minute;
      req_now_second  = cur_now.second;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      port_result_q.push_back(rtc_port_step(op, val, cur_now));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic port_write(input logic [7:0] val);
      send_beat(OP_WRITE, val);
   endtask

   task automatic port_read();
      send_beat(OP_READ, 8'($urandom));
   endtask

   // One SCK pulse; SIO is driven to b only when drive is set.
   task automatic clock_bit(input logic b, input logic drive);
      logic [7:0] junk;
      junk = 8'($urandom) & IGNORED_BITS;
      if (drive)
         port_write(WE_SIO | WE_SCK | WE_CS | LINE_SCK | LINE_CS | (b ? LINE_SIO : 8'h00) | junk);
      else
         port_write(WE_SCK | WE_CS | LINE_SCK | LINE_CS | junk);
      port_write(WE_SCK | junk);
   endtask

   // Toggle chip select and clock in one raw command byte.
   task automatic send_command_byte(input logic [7:0] raw);
      port_write(WE_CS);
      port_write(WE_SCK | WE_CS | LINE_SCK | LINE_CS);
      for (int i = 0; i < 8; i++) clock_bit(raw[i], 1'b1);
   endtask

   // Full (or cut-off) transfer; arg is the first data byte of a write.
   task automatic run_transfer(input logic rd, input logic [2:0] sel, input logic flip,
                               input logic cut, input logic [7:0] arg);
      logic [7:0] cmd;
      int         total;
      cmd = {rd, sel, CMD_MARKER};
      send_command_byte(flip ? flip_byte(cmd) : cmd);
      total = 8 * xfer_length(sel);
      if (cut) total = $urandom_range(total - 1, 0);
      for (int i = 0; i < total; i++) begin
         if (i < 8)
            clock_bit(arg[i], rd ? 1'(($urandom_range(1))) : 1'b1);
         else
            clock_bit(1'($urandom_range(1)), rd ? 1'($urandom_range(1)) : 1'b1);
         if ($urandom_range(15) == 0) port_read();
      end
   endtask

   // Line levels, write enables and the ignored bits of a port write.
   task automatic test_port_lines();
      port_read();
      port_write(8'h77);
      port_write(8'h88);
      port_write(8'h70);
      port_write(8'hFF);
      port_write(8'h00);
      port_read();
   endtask

   // Both command bit orders and bytes of unknown format.
   task automatic test_command_formats();
      run_transfer(1'b1, REG_STATUS_ONE, 1'b0, 1'b0, 8'h00);
      run_transfer(1'b1, REG_STATUS_TWO, 1'b1, 1'b0, 8'h00);
      send_command_byte(8'h00);
      send_command_byte(8'hFF);
      send_command_byte(8'hA5);
   endtask

   // Status one keeps only bits 1-3; status two takes the whole byte.
   task automatic test_status_registers();
      run_transfer(1'b0, REG_STATUS_ONE, 1'b0, 1'b0, 8'hFF);
      run_transfer(1'b1, REG_STATUS_ONE, 1'b1, 1'b0, 8'h00);
      run_transfer(1'b0, REG_STATUS_TWO, 1'b1, 1'b0, 8'hA5);
      run_transfer(1'b1, REG_STATUS_TWO, 1'b0, 1'b0, 8'h00);
   endtask

   // Date/time and time reads at the extremes of the current-time inputs.
   task automatic test_clock_reads();
      now_fixed = 1'b1;
      cur_now = '1;
      run_transfer(1'b1, REG_DATE_TIME, 1'b1, 1'b0, 8'h00);
      cur_now = '{year: 7'd99, month: 4'd12, day: 5'd31, weekday: 3'd6,
                  hour: 5'd23, minute: 6'd59, second: 6'd59};
      run_transfer(1'b1, REG_TIME, 1'b0, 1'b0, 8'h00);
      now_fixed = 1'b0;
   endtask

   // A clock write is swallowed; alarm and free registers read zero.
   task automatic test_ignored_registers();
      run_transfer(1'b0, REG_TIME, 1'b0, 1'b0, 8'h12);
      run_transfer(1'b0, REG_ALARM_ONE, 1'b1, 1'b0, 8'hFF);
      run_transfer(1'b1, REG_ALARM_ONE, 1'b0, 1'b0, 8'h00);
      run_transfer(1'b1, REG_FREE, 1'b1, 1'b0, 8'h00);
   endtask

   // Mostly well-formed transfers with random content, plus broken ones and noise.
   task automatic test_random_traffic(input int beats);
      int stop_at;
      int pick;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70)
            run_transfer(1'($urandom_range(1)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                         $urandom_range(4) == 0, 8'($urandom));
         else if (pick < 80)
            send_command_byte(8'($urandom));
         else
            repeat ($urandom_range(6, 1)) send_beat(1'($urandom_range(1)), 8'($urandom));
      end
   endtask

   // Main sequence.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_READ;
      req_port_value  = 8'h00;
      req_now_year    = '0;
      req_now_month   = '0;
      req_now_day     = '0;
      req_now_weekday = '0;
      req_now_hour    = '0;
      req_now_minute  = '0;
      req_now_second  = '0;
      cur_now         = '0;
      line_lv    = '0;
      line_we    = '0;
      bit_idx    = '0;
      byte_idx   = '0;
      shifter    = '0;
      xfer_phase = PHASE_COMMAND;
      cur_reg    = '0;
      stat_one   = '0;
      stat_two   = '0;
      for (int i = 0; i < BUFFER_BYTES; i++) xfer_buf[i] = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_port_lines();
      test_command_formats();
      test_status_registers();
      test_clock_reads();
      test_ignored_registers();

      send_idle_pct = 21;
      recv_stall_pct = 57;
      test_random_traffic(100);
      send_idle_pct = 57;
      recv_stall_pct = 21;
      test_random_traffic(100);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(100);
      req_valid = 1'b0;

      // Drain, then watch a little longer for stray result beats.
      while (port_result_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && port_result_q.size() == 0)
         $display("tb_three_wire_rtc_serial_port_top: done, clean");
      else
         $display("tb_three_wire_rtc_serial_port_top: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/twrtc_pkg.sv
sv/twrtc_clock_fmt.sv
sv/twrtc_engine.sv
sv/three_wire_rtc_serial_port_top.sv
tb/tb_three_wire_rtc_serial_port_top.sv
